>>> design/blid_pkg.sv
package blid_pkg;

    // Fixed payload widths of the channels.
    localparam int VALUE_W    = 32;
    localparam int ACTION_W   = 2;
    localparam int POSITION_W = 6;

    // Default list capacity, handed to the top level parameter.
    localparam int DEF_CAPACITY = 64;

    typedef logic signed [VALUE_W-1:0]  t_word;
    typedef logic        [ACTION_W-1:0] t_action;
    typedef logic        [POSITION_W-1:0] t_position;

    // Input action codes. The last code leaves the list as it is.
    localparam t_action ACT_FRONT  = 2'd0;
    localparam t_action ACT_BACK   = 2'd1;
    localparam t_action ACT_DELETE = 2'd2;
    localparam t_action ACT_NOP    = 2'd3;

    // Operations broadcast to every cell of the chain.
    typedef logic [2:0] t_cell_op;
    localparam t_cell_op OP_HOLD   = 3'd0;  // keep the stored value
    localparam t_cell_op OP_PUSH   = 3'd1;  // take the left neighbor
    localparam t_cell_op OP_LOAD   = 3'd2;  // marked cell takes the new value
    localparam t_cell_op OP_PULL   = 3'd3;  // marked cells take the right neighbor
    localparam t_cell_op OP_ROTATE = 3'd4;  // right neighbor, marked cell takes the front

    typedef struct packed {
        t_cell_op op;
        t_word    value;
    } t_cell_ctrl;

endpackage

>>> design/blid_if.sv
interface blid_in_if;
    import blid_pkg::*;

    logic      valid;
    logic      ready;
    t_action   action;
    t_word     value;
    t_position position;

    modport source (output valid, output action, output value, output position, input ready);
    modport sink   (input valid, input action, input value, input position, output ready);
endinterface

interface blid_out_if;
    import blid_pkg::*;

    logic  valid;
    logic  ready;
    t_word entry_value;
    logic  is_last;
    logic  list_empty;
    logic  insert_dropped;

    modport source (
        output valid, output entry_value, output is_last, output list_empty,
        output insert_dropped, input ready
    );
    modport sink (
        input valid, input entry_value, input is_last, input list_empty,
        input insert_dropped, output ready
    );
endinterface

>>> design/bounded_list_insert_delete_unit.sv
// Channel   Modport      Payload                                          Transfer
// i_in      sink         action, value, position                          valid && ready
// o_out     source       entry_value, is_last, list_empty, insert_dropped valid && ready
//
// Each item first applies its edit to the chain, then streams one result per
// entry when the list is not empty, or a single empty marker when it is.
// The single front cell of the chain presents the results, one entry per
// output transfer, while the chain rotates behind it.
// The synchronous reset i_rst_n empties the list; entry contents are not cleared.
// A stall on o_out simply holds the chain; no new item is taken until the
// last result of the current one has been transferred.
module bounded_list_insert_delete_unit #(
    parameter int CAPACITY = blid_pkg::DEF_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    blid_in_if.sink     i_in,
    blid_out_if.source  o_out
);
    import blid_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    // Common width for comparing the 6-bit position against the count.
    localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEND = 1'b1;

    logic             r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx,   n_idx;
    logic             r_drop,  n_drop;

    t_cell_ctrl w_ctrl;
    t_word      w_value [CAPACITY];
    logic       w_mark  [CAPACITY];

    logic             w_in_xfer;
    logic             w_out_xfer;
    logic             w_full;
    logic             w_pos_ok;
    logic             w_empty;
    logic             w_last;
    logic [CNT_W-1:0] w_last_idx;

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_xfer = o_out.valid && o_out.ready;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_pos_ok   = (CMP_W'(i_in.position) < CMP_W'(r_count));
    assign w_empty    = (r_count == '0);
    assign w_last_idx = r_count - 1'b1;
    assign w_last     = w_empty || (r_idx == w_last_idx);

    // The sequencer: edit the chain when an item is transferred in, then
    // stream the list by rotating it once around its occupied cells.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_drop       = r_drop;
        w_ctrl.op    = OP_HOLD;
        w_ctrl.value = i_in.value;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = ST_SEND;
                    n_idx   = '0;
                    n_drop  = 1'b0;
                    unique case (i_in.action)
                        ACT_FRONT: begin
                            if (w_full) begin
                                n_drop = 1'b1;
                            end else begin
                                w_ctrl.op = OP_PUSH;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        ACT_BACK: begin
                            if (w_full) begin
                                n_drop = 1'b1;
                            end else begin
                                w_ctrl.op = OP_LOAD;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        ACT_DELETE: begin
                            if (w_pos_ok) begin
                                w_ctrl.op = OP_PULL;
                                n_count   = r_count - 1'b1;
                            end
                        end
                        default: begin
                            // Unused action code: the list is streamed unchanged.
                        end
                    endcase
                end
            end
            ST_SEND: begin
                if (w_out_xfer) begin
                    if (!w_empty) begin
                        w_ctrl.op = OP_ROTATE;
                    end
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_drop  <= n_drop;
        end
    end

    // The chain of cells. Each cell decodes its own mark from its fixed index:
    // the append slot, the tail of a delete, or the wrap point of a rotation.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        t_word w_left;
        t_word w_right;

        if (k == 0) begin : g_front
            assign w_left = i_in.value;
        end else begin : g_mid
            assign w_left = w_value[k-1];
        end

        if (k == CAPACITY - 1) begin : g_back
            assign w_right = w_value[k];
        end else begin : g_inner
            assign w_right = w_value[k+1];
        end

        always_comb begin
            case (w_ctrl.op)
                OP_LOAD:   w_mark[k] = (CNT_W'(k) == r_count);
                OP_PULL:   w_mark[k] = (CMP_W'(k) >= CMP_W'(i_in.position));
                OP_ROTATE: w_mark[k] = (CNT_W'(k) == w_last_idx);
                default:   w_mark[k] = 1'b0;
            endcase
        end

        blid_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_mark  (w_mark[k]),
            .i_left  (w_left),
            .i_right (w_right),
            .i_front (w_value[0]),
            .o_value (w_value[k])
        );
    end

    assign i_in.ready           = (r_state == ST_IDLE);
    assign o_out.valid          = (r_state == ST_SEND);
    assign o_out.entry_value    = w_empty ? '0 : w_value[0];
    assign o_out.is_last        = w_last;
    assign o_out.list_empty     = w_empty;
    assign o_out.insert_dropped = r_drop;

    // The block never takes an item while results are still pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input taken while results pending");

    // The fill count never passes the capacity.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // Every accepted item leads to results in the next cycle.
    a_results_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> o_out.valid)
        else $error("no results after input transfer");

    // An empty list answers with a single, final result.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.list_empty) |-> o_out.is_last)
        else $error("empty result not marked last");

    // A dropped insert means the list was full and stays full.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.insert_dropped) |-> w_full)
        else $error("insert dropped on a list that is not full");

endmodule

>>> design/blid_cell.sv
module blid_cell (
    input  logic                i_clk,
    input  blid_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_mark,
    input  blid_pkg::t_word     i_left,
    input  blid_pkg::t_word     i_right,
    input  blid_pkg::t_word     i_front,
    output blid_pkg::t_word     o_value
);
    import blid_pkg::*;

    t_word r_value;
    t_word n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            OP_PUSH:   n_value = i_left;
            OP_LOAD:   n_value = i_mark ? i_ctrl.value : r_value;
            OP_PULL:   n_value = i_mark ? i_right : r_value;
            OP_ROTATE: n_value = i_mark ? i_front : i_right;
            default:   n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

>>> dv/bounded_list_insert_delete_unit_tb.sv
`timescale 1ns / 100ps

module bounded_list_insert_delete_unit_tb;
    import blid_pkg::*;

    localparam int CAP         = DEF_CAPACITY;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 80;

    // One streamed entry as the block should present it.
    typedef struct packed {
        t_word entry_value;
        logic  is_last;
        logic  list_empty;
        logic  insert_dropped;
    } t_list_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    blid_in_if  in_ch ();
    blid_out_if out_ch ();

    bounded_list_insert_delete_unit #(
        .CAPACITY(CAP)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow copy of the list, kept in step with every item that is sent.
    t_word        shadow_list [CAP];
    int           shadow_count;
    t_list_result stream_expect [$];

    int mismatch_count = 0;
    int cycle_count    = 0;

    // When set, the sender or the receiver runs without any gaps.
    bit steady_feed  = 1'b0;
    bit steady_drain = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // A hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bounded_list_insert_delete_unit regression: fail");
            $finish;
        end
    end

    function automatic void note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    // Most gaps are short; a few are long enough to span a short stream.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 20);
        end
    endfunction

    function automatic t_word pick_value();
        int roll;
        roll = $urandom_range(0, 19);
        case (roll)
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return '1;
            default: return t_word'($urandom);
        endcase
    endfunction

    // Applies one edit to the shadow list and queues the stream that
    // follows it: either every entry front to back, or one empty marker.
    function automatic void predict_list_stream(t_action act, t_word val, t_position pos);
        logic dropped;
        t_list_result res;
        dropped = 1'b0;
        case (act) inside
            ACT_FRONT, ACT_BACK: begin
                if (shadow_count >= CAP) begin
                    dropped = 1'b1;
                end else if (act == ACT_FRONT) begin
                    for (int k = shadow_count; k > 0; k--) begin
                        shadow_list[k] = shadow_list[k-1];
                    end
                    shadow_list[0] = val;
                    shadow_count++;
                end else begin
                    shadow_list[shadow_count] = val;
                    shadow_count++;
                end
            end
            ACT_DELETE: begin
                if (int'(pos) < shadow_count) begin
                    for (int k = int'(pos); k < shadow_count - 1; k++) begin
                        shadow_list[k] = shadow_list[k+1];
                    end
                    shadow_count--;
                end
            end
            default: begin
            end
        endcase

        if (shadow_count == 0) begin
            res = '{entry_value: '0, is_last: 1'b1, list_empty: 1'b1, insert_dropped: dropped};
            stream_expect.push_back(res);
        end else begin
            for (int k = 0; k < shadow_count; k++) begin
                res.entry_value    = shadow_list[k];
                res.is_last        = (k == shadow_count - 1);
                res.list_empty     = 1'b0;
                res.insert_dropped = dropped;
                stream_expect.push_back(res);
            end
        end
    endfunction

    // Sends one item. The task is entered at a clock edge and returns at the
    // edge where the transfer took place, with valid still high, so that the
    // next item can follow back to back.
    task automatic send_item(t_action act, t_word val, t_position pos);
        int gap;
        gap = steady_feed ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        predict_list_stream(act, val, pos);
        in_ch.valid    <= 1'b1;
        in_ch.action   <= act;
        in_ch.value    <= val;
        in_ch.position <= pos;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
    endtask

    // Holds the sender off until every queued result has been seen.
    task automatic wait_stream_drained();
        in_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (stream_expect.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    // A random delete target somewhere inside the current list.
    function automatic t_position pick_live_position();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            return '0;
        end else if (roll == 1) begin
            return t_position'(shadow_count - 1);
        end else begin
            return t_position'($urandom_range(0, shadow_count - 1));
        end
    endfunction

    // A random delete target at or beyond the end of the list, or anywhere in it when full.
    function automatic t_position pick_dead_position();
        if (shadow_count >= CAP) begin
            return t_position'($urandom_range(0, CAP - 1));
        end
        return t_position'($urandom_range(shadow_count, CAP - 1));
    endfunction

    task automatic send_noise();
        if ($urandom_range(0, 1) == 0 || shadow_count >= CAP) begin
            send_item(ACT_NOP, t_word'($urandom), t_position'($urandom));
        end else begin
            send_item(ACT_DELETE, t_word'($urandom), pick_dead_position());
        end
    endtask

    task automatic send_random_insert();
        t_action act;
        act = ($urandom_range(0, 1) == 0) ? ACT_FRONT : ACT_BACK;
        send_item(act, pick_value(), t_position'($urandom));
    endtask

    // Receiver: ready is mostly high, with short stalls and now and then a
    // long one.
    initial begin
        int stall_left;
        int roll;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0 && !steady_drain) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                stall_left = 0;
                roll = $urandom_range(0, 99);
                if (roll < 12) begin
                    stall_left = $urandom_range(1, 3);
                end else if (roll < 14) begin
                    stall_left = $urandom_range(8, 20);
                end
            end
        end
    end

    // Every result transfer is matched against the oldest expected entry.
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (stream_expect.size() == 0) begin
                note_mismatch($sformatf(
                    "unexpected result: value %0d last %0b empty %0b dropped %0b",
                    out_ch.entry_value, out_ch.is_last, out_ch.list_empty,
                    out_ch.insert_dropped));
            end else begin
                want = stream_expect.pop_front();
                if (out_ch.entry_value !== want.entry_value ||
                    out_ch.is_last !== want.is_last ||
                    out_ch.list_empty !== want.list_empty ||
                    out_ch.insert_dropped !== want.insert_dropped) begin
                    note_mismatch($sformatf(
                        {"mismatch at cycle %0d: expected value %0d last %0b empty %0b ",
                         "dropped %0b, got value %0d last %0b empty %0b dropped %0b"},
                        cycle_count, want.entry_value, want.is_last, want.list_empty,
                        want.insert_dropped, out_ch.entry_value, out_ch.is_last,
                        out_ch.list_empty, out_ch.insert_dropped));
                end
            end
        end
    end

    // Deletes and the idle action on a list that holds nothing.
    task automatic test_empty_list();
        send_item(ACT_DELETE, '0, '0);
        send_item(ACT_DELETE, '1, '1);
        send_item(ACT_NOP, '1, '1);
    endtask

    // Extreme values at both ends, with the unused fields set.
    task automatic test_field_extremes();
        send_item(ACT_FRONT, 32'sh7FFF_FFFF, '1);
        send_item(ACT_BACK, 32'sh8000_0000, '0);
        send_item(ACT_FRONT, '0, 6'h2A);
        send_item(ACT_BACK, '1, 6'h15);
        send_item(ACT_FRONT, 32'sh5A5A_A5A5, '0);
        send_item(ACT_NOP, t_word'($urandom), t_position'($urandom));
    endtask

    // Deletes past the end, at the back, in the middle and at the front, then one append.
    task automatic test_delete_positions();
        send_item(ACT_DELETE, '1, t_position'(shadow_count));
        send_item(ACT_DELETE, '0, '1);
        send_item(ACT_DELETE, t_word'($urandom), t_position'(shadow_count - 1));
        send_item(ACT_DELETE, '0, 6'd1);
        send_item(ACT_DELETE, '0, 6'd0);
        send_item(ACT_BACK, pick_value(), '0);
        wait_stream_drained();
    endtask

    // Grows the list to capacity, then keeps pushing so inserts are refused.
    task automatic test_fill_and_overflow();
        int roll;
        int sent;
        sent = 0;
        while (shadow_count < CAP) begin
            steady_feed = (sent >= 20 && sent < 40);
            roll = $urandom_range(0, 99);
            if (roll < 94) begin
                send_random_insert();
            end else if (roll < 97 && shadow_count > 0) begin
                send_item(ACT_DELETE, t_word'($urandom), pick_live_position());
            end else begin
                send_noise();
            end
            sent++;
        end
        steady_feed = 1'b0;
        repeat (5) send_random_insert();
    endtask

    // Edits at and around capacity, so drops and deletes interleave.
    task automatic test_churn_near_full();
        int roll;
        steady_drain = 1'b1;
        repeat (12) begin
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                send_random_insert();
            end else if (roll < 90 && shadow_count > 0) begin
                send_item(ACT_DELETE, t_word'($urandom), pick_live_position());
            end else begin
                send_noise();
            end
        end
        steady_drain = 1'b0;
        wait_stream_drained();
    endtask

    // A run of deletes on a long list, with a few ignored items mixed in.
    task automatic test_delete_run();
        int roll;
        repeat (12) begin
            roll = $urandom_range(0, 99);
            if (roll < 85 && shadow_count > 0) begin
                send_item(ACT_DELETE, t_word'($urandom), pick_live_position());
            end else begin
                send_noise();
            end
        end
    endtask

    // Unshaped items: any action, any position.
    task automatic test_random_mix();
        repeat (12) begin
            send_item(t_action'($urandom_range(0, 3)), pick_value(), t_position'($urandom));
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.action   <= ACT_FRONT;
        in_ch.value    <= '0;
        in_ch.position <= '0;
        shadow_count   = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_field_extremes();
        test_delete_positions();
        test_fill_and_overflow();
        test_churn_near_full();
        test_delete_run();
        test_random_mix();

        wait_stream_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && stream_expect.size() == 0) begin
            $display("bounded_list_insert_delete_unit regression: pass");
        end else begin
            $display("bounded_list_insert_delete_unit regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/blid_pkg.sv
design/blid_if.sv
design/blid_cell.sv
design/bounded_list_insert_delete_unit.sv
dv/bounded_list_insert_delete_unit_tb.sv
